>>> design/uqf_pkg.sv
// Shared types, codes and constants for the unique-key request queue.
package uqf_pkg;

  localparam int unsigned KEY_BITS          = 8;
  localparam int unsigned HANDLE_BITS       = 16;
  localparam int unsigned STATUS_BITS       = 3;
  localparam int unsigned FILL_BITS         = 5;
  localparam int unsigned QUEUE_DEPTH_DEF   = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_POP    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_NONE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP_RD,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]             command;
    logic [KEY_BITS-1:0]    requester_key;
    logic [HANDLE_BITS-1:0] request_handle;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [KEY_BITS-1:0]    popped_key;
    logic [HANDLE_BITS-1:0] popped_handle;
    logic [FILL_BITS-1:0]   fill_level;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic pop_read;
    logic finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_blocked;
  } dp_stat_t;

endpackage

>>> design/unique_key_request_fifo.sv
// Top level of the unique-key request queue: controller plus datapath.
// Ordered queue of (requester_key, request_handle) entries, one per key.
// Input channel (in_valid_i / in_stall_o / in_word_i) takes one command word:
//   add appends unless the key is queued or the queue is full, cancel drops
//   every entry with the key, pop returns the oldest entry.
// Output channel (out_valid_o / out_stall_i / out_word_o) returns exactly
//   one result word per command, in order, with the fill level after it.
// One command is in work at a time. Add and cancel first scan the queued
//   entries (the scan walks the entry memory one read per cycle, then the
//   last read data is checked and the scan end is seen), pop first reads
//   the head entry and code 3 goes straight on; each ends in a finish
//   step that writes the result register. No new command is taken until
//   the finish step of the last one is done.
// A finished result waits in the output register; a new command is taken
// meanwhile and only its finish step waits while out_stall_i is high.
// Reset empties the queue and clears out_valid_o; entry contents are not
// cleared and need no init pass.
module unique_key_request_fifo #(
  parameter int unsigned QUEUE_DEPTH = uqf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  uqf_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uqf_pkg::out_word_t out_word_o
);
  import uqf_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  uqf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_word_i.command),
    .in_stall_o   (in_stall_o),
    .dp_stat_i    (dp_stat),
    .dp_cmd_o     (dp_cmd)
  );

  uqf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .dp_cmd_i    (dp_cmd),
    .dp_stat_o   (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> design/uqf_ctrl.sv
// Sequencing state machine for the unique-key request queue.
module uqf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_command_i,
  output logic             in_stall_o,
  input  uqf_pkg::dp_stat_t dp_stat_i,
  output uqf_pkg::dp_cmd_t  dp_cmd_o
);
  import uqf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_command_i)
            CMD_ADD, CMD_CANCEL: state_d = S_SCAN;
            CMD_POP:             state_d = S_POP_RD;
            default:             state_d = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (dp_stat_i.scan_done) state_d = S_FINISH;
      end
      S_POP_RD: state_d = S_FINISH;
      S_FINISH: begin
        if (!dp_stat_i.out_blocked) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o        = (state_q != S_IDLE);
    dp_cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    dp_cmd_o.scan     = (state_q == S_SCAN);
    dp_cmd_o.pop_read = (state_q == S_POP_RD);
    dp_cmd_o.finish   = (state_q == S_FINISH) && !dp_stat_i.out_blocked;
  end

endmodule

>>> design/uqf_datapath.sv
// Entry memory, circular pointers, scan unit and result register.
module uqf_datapath #(
  parameter int unsigned QUEUE_DEPTH = uqf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uqf_pkg::in_word_t in_word_i,
  input  uqf_pkg::dp_cmd_t  dp_cmd_i,
  output uqf_pkg::dp_stat_t dp_stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output uqf_pkg::out_word_t out_word_o
);
  import uqf_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = KEY_BITS + HANDLE_BITS;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] a, logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PW+1)'(QUEUE_DEPTH)) s = s - (PW+1)'(QUEUE_DEPTH);
    return s[PW-1:0];
  endfunction

  logic [EW-1:0] mem_q [QUEUE_DEPTH];
  logic [EW-1:0] rdata_q;

  cmd_e                   cmd_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [PW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          wr_q, wr_d;
  logic                   rv_q, rv_d;
  logic                   dup_q, dup_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_q, out_d;

  logic                   issue, rd_en, match, we;
  logic [PW-1:0]          rd_addr, wr_addr;
  logic [EW-1:0]          wdata;
  logic [KEY_BITS-1:0]    rd_key;

  assign rd_key = rdata_q[EW-1:HANDLE_BITS];
  assign issue  = dp_cmd_i.scan && (idx_q != count_q);
  assign rd_en  = issue || dp_cmd_i.pop_read;
  assign rd_addr = issue ? wrap_add(head_q, idx_q[PW-1:0]) : head_q;
  assign match  = rv_q && (rd_key == key_q);

  always_comb begin
    idx_d       = idx_q;
    wr_d        = wr_q;
    dup_d       = dup_q;
    rv_d        = issue;
    head_d      = head_q;
    count_d     = count_q;
    we          = 1'b0;
    wr_addr     = wrap_add(head_q, wr_q[PW-1:0]);
    wdata       = rdata_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (dp_cmd_i.accept) begin
      idx_d = '0;
      wr_d  = '0;
      dup_d = 1'b0;
    end
    if (issue) idx_d = idx_q + CW'(1);
    if (match) dup_d = 1'b1;
    // cancel compaction: surviving entries slide toward the head
    if (rv_q && (cmd_q == CMD_CANCEL) && !match) begin
      we   = 1'b1;
      wr_d = wr_q + CW'(1);
    end

    if (dp_cmd_i.finish) begin
      out_d.status        = ST_DONE;
      out_d.popped_key    = '0;
      out_d.popped_handle = '0;
      case (cmd_q)
        CMD_ADD: begin
          if (dup_q) begin
            out_d.status = ST_DUP;
          end else if (count_q == CW'(QUEUE_DEPTH)) begin
            out_d.status = ST_FULL;
          end else begin
            we      = 1'b1;
            wr_addr = wrap_add(head_q, count_q[PW-1:0]);
            wdata   = {key_q, handle_q};
            count_d = count_q + CW'(1);
          end
        end
        CMD_CANCEL: begin
          if (wr_q == count_q) out_d.status = ST_NONE;
          count_d = wr_q;
        end
        CMD_POP: begin
          if (count_q == '0) begin
            out_d.status = ST_EMPTY;
          end else begin
            out_d.popped_key    = rd_key;
            out_d.popped_handle = rdata_q[HANDLE_BITS-1:0];
            head_d  = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
            count_d = count_q - CW'(1);
          end
        end
        default: ;
      endcase
      out_d.fill_level = FILL_BITS'(count_d);
      out_valid_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_addr] <= wdata;
    if (rd_en) rdata_q <= mem_q[rd_addr];
    if (dp_cmd_i.accept) begin
      cmd_q    <= cmd_e'(in_word_i.command);
      key_q    <= in_word_i.requester_key;
      handle_q <= in_word_i.request_handle;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      wr_q        <= '0;
      rv_q        <= 1'b0;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      wr_q        <= wr_d;
      rv_q        <= rv_d;
      dup_q       <= dup_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign dp_stat_o.scan_done   = (idx_q == count_q) && !rv_q;
  assign dp_stat_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.scan |-> (wr_q <= idx_q) && (idx_q <= count_q))
    else $error("compaction write index passed read index");

  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !dp_cmd_i.finish)
    else $error("result register overwritten while held");

endmodule
